// File: rtl/dda_pkg.sv
`default_nettype none

package dda_pkg;

  // command codes carried by each input beat
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // back end sequencer codes
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  // queue status seen by the front end and the back end
  typedef struct packed {
    logic empty;
    logic full;
  } dda_q_stat_t;

endpackage

`default_nettype wire

// File: rtl/dda_line_rasterizer.sv
// DDA line rasterizer. A load beat (command 0) takes two endpoints, returns
// the start point at once and then runs a restoring divider per axis to form
// both axis increments; step beats (command 1) that arrive meanwhile wait in
// a two-entry command queue. Outside that window the back end emits one point
// per cycle while the output slot is free or popped, one point for each step
// beat, rounded to nearest with halves away from zero on the magnitude of the
// position. The last point of a line carries last_point; a step with no line
// active returns a beat with point_valid low and zero fields. A result beat
// sits in a one-entry output slot that the next beat may refill in the cycle
// it is popped. No clearing pass follows reset.
`default_nettype none

module dda_line_rasterizer #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_push,
  output logic                         in_full,
  input  wire                          in_command,
  input  wire signed [COORD_BITS-1:0]  in_start_x,
  input  wire signed [COORD_BITS-1:0]  in_start_y,
  input  wire signed [COORD_BITS-1:0]  in_end_x,
  input  wire signed [COORD_BITS-1:0]  in_end_y,
  output logic                         out_empty,
  input  wire                          out_pop,
  output logic [COORD_BITS-1:0]        out_point_x,
  output logic [COORD_BITS-1:0]        out_point_y,
  output logic                         out_point_valid,
  output logic                         out_last_point
);
  import dda_pkg::*;

  localparam int EW          = 5 * COORD_BITS + 3;
  localparam int QUEUE_DEPTH = 2;

  dda_q_stat_t   q_stat;
  logic          q_push, q_pop;
  logic [EW-1:0] q_wdata, q_rdata;

  dda_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .in_push    (in_push),
    .in_full    (in_full),
    .in_command (in_command),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  dda_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  dda_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_valid (out_point_valid),
    .out_last_point  (out_last_point)
  );

endmodule

`default_nettype wire

// File: rtl/dda_front.sv
`default_nettype none

module dda_front #(
  parameter int COORD_BITS = 11
) (
  input  wire                           in_push,
  output logic                          in_full,
  input  wire                           in_command,
  input  wire signed [COORD_BITS-1:0]   in_start_x,
  input  wire signed [COORD_BITS-1:0]   in_start_y,
  input  wire signed [COORD_BITS-1:0]   in_end_x,
  input  wire signed [COORD_BITS-1:0]   in_end_y,
  input  dda_pkg::dda_q_stat_t          q_stat,
  output logic                          q_push,
  output logic [5*COORD_BITS+2:0]       q_wdata
);
  import dda_pkg::*;

  localparam int C = COORD_BITS;

  logic [C:0]   dx, dy;
  logic [C-1:0] ax, ay, steps;

  // deltas one bit wider than the coordinates
  assign dx = {in_end_x[C-1], in_end_x} - {in_start_x[C-1], in_start_x};
  assign dy = {in_end_y[C-1], in_end_y} - {in_start_y[C-1], in_start_y};

  // magnitudes fit in C bits since |delta| <= 2^C - 1
  always_comb begin
    logic [C:0] nx, ny;
    nx = -dx;
    ny = -dy;
    ax = dx[C] ? nx[C-1:0] : dx[C-1:0];
    ay = dy[C] ? ny[C-1:0] : dy[C-1:0];
    steps = (ax > ay) ? ax : ay;
  end

  // queue entry: cmd, sx, sy, neg_x, neg_y, ax, ay, steps
  assign q_wdata = {in_command, in_start_x, in_start_y, dx[C], dy[C], ax, ay, steps};
  assign q_push  = in_push && !q_stat.full;
  assign in_full = q_stat.full;

endmodule

`default_nettype wire

// File: rtl/dda_queue.sv
`default_nettype none

module dda_queue #(
  parameter int WIDTH = 58,
  parameter int DEPTH = 2
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  wire  [WIDTH-1:0]       wdata,
  input  wire                    pop,
  output logic [WIDTH-1:0]       rdata,
  output dda_pkg::dda_q_stat_t   stat
);
  import dda_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign stat  = '{empty: (count_r == '0), full: (count_r == CW'(DEPTH))};

endmodule

`default_nettype wire

// File: rtl/dda_back.sv
`default_nettype none

module dda_back #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 16
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  dda_pkg::dda_q_stat_t        q_stat,
  input  wire  [5*COORD_BITS+2:0]     q_rdata,
  output logic                        q_pop,
  output logic                        out_empty,
  input  wire                         out_pop,
  output logic [COORD_BITS-1:0]       out_point_x,
  output logic [COORD_BITS-1:0]       out_point_y,
  output logic                        out_point_valid,
  output logic                        out_last_point
);
  import dda_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int P  = C + F + 1;           // position width
  localparam int IW = F + 2;               // increment width, |inc| <= 1.0
  localparam int NW = C + F + 1;           // rounded dividend width
  localparam int KW = $clog2(F + 2);       // divider iteration counter

  // unpacked queue head
  logic         h_cmd, h_neg_x, h_neg_y;
  logic [C-1:0] h_sx, h_sy, h_ax, h_ay, h_steps;

  assign {h_cmd, h_sx, h_sy, h_neg_x, h_neg_y, h_ax, h_ay, h_steps} = q_rdata;

  // line state
  logic            state_r;
  logic [P-1:0]    pos_x_r, pos_y_r;
  logic [IW-1:0]   inc_x_r, inc_y_r;
  logic [C-1:0]    steps_rem_r;
  logic            active_r;

  // divider state
  logic [KW-1:0]   div_cnt_r;
  logic [C-1:0]    div_den_r;
  logic [C-1:0]    rem_x_r, rem_y_r;
  logic [F:0]      lo_x_r, lo_y_r;
  logic            neg_x_r, neg_y_r;

  // output slot
  logic            out_valid_r;
  logic [C-1:0]    out_x_r, out_y_r;
  logic            out_pv_r, out_last_r;

  function automatic logic [C-1:0] round_mag(input logic [P-1:0] p);
    logic [P-1:0] m;
    logic [P-1:0] s;
    m = p[P-1] ? (~p + 1'b1) : p;
    s = m + {{(P-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    return s[F+C-1:F];
  endfunction

  // emit control
  logic emit_ok;
  assign emit_ok = !out_valid_r || out_pop;
  assign q_pop   = (state_r == ST_IDLE) && !q_stat.empty && emit_ok;

  // step path
  logic [P-1:0] step_x, step_y;
  assign step_x = pos_x_r + {{(P-IW){inc_x_r[IW-1]}}, inc_x_r};
  assign step_y = pos_y_r + {{(P-IW){inc_y_r[IW-1]}}, inc_y_r};

  // load path: start position and rounded dividends
  logic [P-1:0]  load_x, load_y;
  logic [NW-1:0] num_x, num_y;
  assign load_x = {h_sx[C-1], h_sx, {F{1'b0}}};
  assign load_y = {h_sy[C-1], h_sy, {F{1'b0}}};
  assign num_x  = {1'b0, h_ax, {F{1'b0}}} + {{(F+1){1'b0}}, (h_steps >> 1)};
  assign num_y  = {1'b0, h_ay, {F{1'b0}}} + {{(F+1){1'b0}}, (h_steps >> 1)};

  // one restoring-division iteration per axis
  logic [C:0]   tx, ty, dfx, dfy;
  logic         gex, gey;
  logic [C-1:0] rem_x_nxt, rem_y_nxt;
  logic [F:0]   lo_x_nxt, lo_y_nxt;
  always_comb begin
    tx  = {rem_x_r, lo_x_r[F]};
    ty  = {rem_y_r, lo_y_r[F]};
    dfx = tx - {1'b0, div_den_r};
    dfy = ty - {1'b0, div_den_r};
    gex = (tx >= {1'b0, div_den_r});
    gey = (ty >= {1'b0, div_den_r});
    rem_x_nxt = gex ? dfx[C-1:0] : tx[C-1:0];
    rem_y_nxt = gey ? dfy[C-1:0] : ty[C-1:0];
    lo_x_nxt  = {lo_x_r[F-1:0], gex};
    lo_y_nxt  = {lo_y_r[F-1:0], gey};
  end

  logic div_last;
  assign div_last = (div_cnt_r == KW'(F));

  // sequencer, line state and divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      steps_rem_r <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      inc_x_r     <= '0;
      inc_y_r     <= '0;
      div_cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            if (h_cmd == CMD_LOAD) begin
              pos_x_r     <= load_x;
              pos_y_r     <= load_y;
              inc_x_r     <= '0;
              inc_y_r     <= '0;
              steps_rem_r <= h_steps;
              active_r    <= (h_steps != '0);
              div_den_r   <= h_steps;
              neg_x_r     <= h_neg_x;
              neg_y_r     <= h_neg_y;
              rem_x_r     <= num_x[NW-1:F+1];
              rem_y_r     <= num_y[NW-1:F+1];
              lo_x_r      <= num_x[F:0];
              lo_y_r      <= num_y[F:0];
              div_cnt_r   <= '0;
              if (h_steps != '0) begin
                state_r <= ST_DIV;
              end
            end else if (active_r) begin
              pos_x_r     <= step_x;
              pos_y_r     <= step_y;
              steps_rem_r <= steps_rem_r - 1'b1;
              active_r    <= (steps_rem_r != C'(1));
            end
          end
        end
        ST_DIV: begin
          rem_x_r   <= rem_x_nxt;
          rem_y_r   <= rem_y_nxt;
          lo_x_r    <= lo_x_nxt;
          lo_y_r    <= lo_y_nxt;
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_last) begin
            inc_x_r <= neg_x_r ? -{1'b0, lo_x_nxt} : {1'b0, lo_x_nxt};
            inc_y_r <= neg_y_r ? -{1'b0, lo_y_nxt} : {1'b0, lo_y_nxt};
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // output slot control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // output slot payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      priority if (h_cmd == CMD_LOAD) begin
        out_x_r    <= round_mag(load_x);
        out_y_r    <= round_mag(load_y);
        out_pv_r   <= 1'b1;
        out_last_r <= (h_steps == '0);
      end else if (active_r) begin
        out_x_r    <= round_mag(step_x);
        out_y_r    <= round_mag(step_y);
        out_pv_r   <= 1'b1;
        out_last_r <= (steps_rem_r == C'(1));
      end else begin
        out_x_r    <= '0;
        out_y_r    <= '0;
        out_pv_r   <= 1'b0;
        out_last_r <= 1'b0;
      end
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_point_x     = out_x_r;
  assign out_point_y     = out_y_r;
  assign out_point_valid = out_pv_r;
  assign out_last_point  = out_last_r;

`ifndef SYNTHESIS
  // no queue beat is taken while the divider runs
  a_no_pop_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !q_pop)
    else $error("queue popped during division");

  // an active line always has steps left
  a_active_steps: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (steps_rem_r != '0))
    else $error("active line with zero steps remaining");

  // divider count never runs past the last quotient bit
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_cnt_r <= KW'(F)))
    else $error("divider count out of range");

  // a queue pop always fills the output slot
  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r)
    else $error("popped beat did not reach the output");

  // a load with a nonzero step count starts the divider
  a_load_div: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && h_cmd == CMD_LOAD && h_steps != '0) |=> (state_r == ST_DIV))
    else $error("load did not start division");
`endif

endmodule

`default_nettype wire
